// ===== hw/rtl/segi_pkg.sv =====
// Shared widths, codes and payload types of the segment intersection block.
package segi_pkg;

  localparam int CB    = 32;              // coordinate bits (COORD_BITS)
  localparam int IW    = 32;              // port field width
  localparam int DW    = CB + 1;          // coordinate difference
  localparam int PW    = 2 * DW;          // product of two differences
  localparam int SW    = PW + 1;          // sum of two products
  localparam int AW    = 2 * CB + 1;      // magnitude of the denominator
  localparam int TL    = CB + 1;          // low slice of the numerator magnitude
  localparam int TH    = AW - TL;         // high slice
  localparam int QB    = CB + 1;          // quotient bits, one per cell
  localparam int NW    = AW + CB + 2;     // scaled dividend
  localparam int DDW   = AW + 1;          // divisor (twice the denominator)
  localparam int RW    = DDW + 1;         // trial remainder
  localparam int IN_W  = 8 * IW;
  localparam int OUT_RAW = 2 + 4 * IW;
  localparam int OUT_W = ((OUT_RAW + 7) / 8) * 8;

  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_ONE  = 2'd1;
  localparam logic [1:0] HIT_TWO  = 2'd2;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic       use_div;
    logic       neg_x;
    logic       neg_y;
    coord_t     fx;
    coord_t     fy;
    coord_t     sx;
    coord_t     sy;
  } side_t;

  typedef struct packed {
    logic [DDW-1:0] rem_x;
    logic [DDW-1:0] rem_y;
    logic [QB-1:0]  nq_x;
    logic [QB-1:0]  nq_y;
    logic [DDW-1:0] den;
    side_t          side;
  } cell_t;

endpackage

// ===== hw/rtl/segi_div_cell.sv =====
// One restoring-division cell: one quotient bit for the x and y offsets.
module segi_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  segi_pkg::cell_t in_cell,
  output logic            out_valid,
  output segi_pkg::cell_t out_cell
);

  logic                      valid_r;
  segi_pkg::cell_t           cell_r;
  segi_pkg::cell_t           cell_nxt;
  logic [segi_pkg::RW-1:0]   dd;
  logic [segi_pkg::RW-1:0]   tx;
  logic [segi_pkg::RW-1:0]   ty;
  logic [segi_pkg::RW-1:0]   dx;
  logic [segi_pkg::RW-1:0]   dy;
  logic                      gex;
  logic                      gey;

  always_comb begin
    dd  = {1'b0, in_cell.den};
    tx  = {in_cell.rem_x, in_cell.nq_x[segi_pkg::QB-1]};
    ty  = {in_cell.rem_y, in_cell.nq_y[segi_pkg::QB-1]};
    dx  = tx - dd;
    dy  = ty - dd;
    gex = (tx >= dd);
    gey = (ty >= dd);
    cell_nxt       = in_cell;
    cell_nxt.rem_x = gex ? dx[segi_pkg::DDW-1:0] : tx[segi_pkg::DDW-1:0];
    cell_nxt.rem_y = gey ? dy[segi_pkg::DDW-1:0] : ty[segi_pkg::DDW-1:0];
    cell_nxt.nq_x  = {in_cell.nq_x[segi_pkg::QB-2:0], gex};
    cell_nxt.nq_y  = {in_cell.nq_y[segi_pkg::QB-2:0], gey};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_cell  = cell_r;

endmodule

// ===== hw/rtl/segi_front.sv =====
// Geometry stages: box reject, cross products, ordering and dividend setup.
module segi_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [segi_pkg::IN_W-1:0] in_data,
  output logic                      out_valid,
  output segi_pkg::cell_t           out_cell
);

  localparam int CB  = segi_pkg::CB;
  localparam int DW  = segi_pkg::DW;
  localparam int PW  = segi_pkg::PW;
  localparam int SW  = segi_pkg::SW;
  localparam int AW  = segi_pkg::AW;
  localparam int TL  = segi_pkg::TL;
  localparam int TH  = segi_pkg::TH;
  localparam int NW  = segi_pkg::NW;
  localparam int QB  = segi_pkg::QB;
  localparam int IW  = segi_pkg::IW;

  function automatic logic signed [DW-1:0] dsub(segi_pkg::coord_t a, segi_pkg::coord_t b);
    logic signed [DW-1:0] ea;
    logic signed [DW-1:0] eb;
    ea = DW'(a);
    eb = DW'(b);
    return ea - eb;
  endfunction

  function automatic logic signed [SW-1:0] sdist(logic signed [PW-1:0] sx,
                                                 logic signed [PW-1:0] sy, logic pos);
    logic signed [SW-1:0] s;
    s = SW'(sx) + SW'(sy);
    return pos ? s : -s;
  endfunction

  // ---- stage 1: input register
  logic              v1_r;
  segi_pkg::coord_t  c1_r [8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++) begin
        c1_r[k] <= in_data[k*IW +: CB];
      end
    end
  end

  // ---- stage 2: differences, box reject, shared endpoints
  segi_pkg::coord_t pxmax, pxmin, qxmax, qxmin, pymax, pymin, qymax, qymin;
  logic             rej;

  always_comb begin
    pxmax = (c1_r[0] > c1_r[2]) ? c1_r[0] : c1_r[2];
    pxmin = (c1_r[0] < c1_r[2]) ? c1_r[0] : c1_r[2];
    pymax = (c1_r[1] > c1_r[3]) ? c1_r[1] : c1_r[3];
    pymin = (c1_r[1] < c1_r[3]) ? c1_r[1] : c1_r[3];
    qxmax = (c1_r[4] > c1_r[6]) ? c1_r[4] : c1_r[6];
    qxmin = (c1_r[4] < c1_r[6]) ? c1_r[4] : c1_r[6];
    qymax = (c1_r[5] > c1_r[7]) ? c1_r[5] : c1_r[7];
    qymin = (c1_r[5] < c1_r[7]) ? c1_r[5] : c1_r[7];
    rej   = (pxmax < qxmin) || (qxmax < pxmin) || (pymax < qymin) || (qymax < pymin);
  end

  logic                  v2_r, rej2_r, qa2_r, qb2_r;
  segi_pkg::coord_t      c2_r [8];
  logic signed [DW-1:0]  pdx2_r, pdy2_r, qdx2_r, qdy2_r, rx2_r, ry2_r;
  logic signed [DW-1:0]  d12x2_r, d12y2_r, d13x2_r, d13y2_r, d14x2_r, d14y2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r    <= c1_r;
      rej2_r  <= rej;
      qa2_r   <= ((c1_r[4] == c1_r[0]) && (c1_r[5] == c1_r[1])) ||
                 ((c1_r[4] == c1_r[2]) && (c1_r[5] == c1_r[3]));
      qb2_r   <= ((c1_r[6] == c1_r[0]) && (c1_r[7] == c1_r[1])) ||
                 ((c1_r[6] == c1_r[2]) && (c1_r[7] == c1_r[3]));
      pdx2_r  <= dsub(c1_r[2], c1_r[0]);
      pdy2_r  <= dsub(c1_r[3], c1_r[1]);
      qdx2_r  <= dsub(c1_r[6], c1_r[4]);
      qdy2_r  <= dsub(c1_r[7], c1_r[5]);
      rx2_r   <= dsub(c1_r[0], c1_r[4]);
      ry2_r   <= dsub(c1_r[5], c1_r[1]);
      d12x2_r <= dsub(c1_r[0], c1_r[2]);
      d12y2_r <= dsub(c1_r[1], c1_r[3]);
      d13x2_r <= dsub(c1_r[0], c1_r[4]);
      d13y2_r <= dsub(c1_r[1], c1_r[5]);
      d14x2_r <= dsub(c1_r[0], c1_r[6]);
      d14y2_r <= dsub(c1_r[1], c1_r[7]);
    end
  end

  // ---- stage 3: products and squares
  logic signed [DW-1:0] aqx, aqy;

  always_comb begin
    aqx = qdx2_r[DW-1] ? -qdx2_r : qdx2_r;
    aqy = qdy2_r[DW-1] ? -qdy2_r : qdy2_r;
  end

  logic                  v3_r, rej3_r, qa3_r, qb3_r;
  segi_pkg::coord_t      c3_r [8];
  logic signed [PW-1:0]  ma3_r, mb3_r, mc3_r, md3_r, me3_r, mf3_r;
  logic signed [PW-1:0]  s12x3_r, s12y3_r, s13x3_r, s13y3_r, s14x3_r, s14y3_r;
  logic                  pos12_3_r, pos13_3_r, pos14_3_r, qxn3_r, qyn3_r;
  logic [CB-1:0]         aqx3_r, aqy3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_r      <= c2_r;
      rej3_r    <= rej2_r;
      qa3_r     <= qa2_r;
      qb3_r     <= qb2_r;
      ma3_r     <= pdy2_r * qdx2_r;
      mb3_r     <= pdx2_r * qdy2_r;
      mc3_r     <= qdy2_r * rx2_r;
      md3_r     <= qdx2_r * ry2_r;
      me3_r     <= pdy2_r * rx2_r;
      mf3_r     <= pdx2_r * ry2_r;
      s12x3_r   <= d12x2_r * d12x2_r;
      s12y3_r   <= d12y2_r * d12y2_r;
      s13x3_r   <= d13x2_r * d13x2_r;
      s13y3_r   <= d13y2_r * d13y2_r;
      s14x3_r   <= d14x2_r * d14x2_r;
      s14y3_r   <= d14y2_r * d14y2_r;
      pos12_3_r <= (d12x2_r > 0) || ((d12x2_r == 0) && (d12y2_r > 0));
      pos13_3_r <= (d13x2_r > 0) || ((d13x2_r == 0) && (d13y2_r > 0));
      pos14_3_r <= (d14x2_r > 0) || ((d14x2_r == 0) && (d14y2_r > 0));
      qxn3_r    <= qdx2_r[DW-1];
      qyn3_r    <= qdy2_r[DW-1];
      aqx3_r    <= aqx[CB-1:0];
      aqy3_r    <= aqy[CB-1:0];
    end
  end

  // ---- stage 4: denominator, numerators, signed squared distances
  logic                  v4_r, rej4_r, qa4_r, qb4_r, qxn4_r, qyn4_r;
  segi_pkg::coord_t      c4_r [8];
  logic signed [SW-1:0]  div4_r, sn4_r, tn4_r, c2d4_r, e1d4_r, e2d4_r;
  logic [CB-1:0]         aqx4_r, aqy4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4_r   <= c3_r;
      rej4_r <= rej3_r;
      qa4_r  <= qa3_r;
      qb4_r  <= qb3_r;
      qxn4_r <= qxn3_r;
      qyn4_r <= qyn3_r;
      aqx4_r <= aqx3_r;
      aqy4_r <= aqy3_r;
      div4_r <= SW'(ma3_r) - SW'(mb3_r);
      sn4_r  <= SW'(mc3_r) + SW'(md3_r);
      tn4_r  <= SW'(me3_r) + SW'(mf3_r);
      c2d4_r <= sdist(s12x3_r, s12y3_r, pos12_3_r);
      e1d4_r <= sdist(s13x3_r, s13y3_r, pos13_3_r);
      e2d4_r <= sdist(s14x3_r, s14y3_r, pos14_3_r);
    end
  end

  // ---- stage 5: range tests, interval sort, magnitudes
  logic                  dneg, ins, intn, swc, swe;
  logic signed [SW-1:0]  adiv, atn;

  always_comb begin
    dneg = div4_r[SW-1];
    ins  = dneg ? ((sn4_r[SW-1] || (sn4_r == 0)) && (sn4_r >= div4_r))
                : (!sn4_r[SW-1] && (sn4_r <= div4_r));
    intn = dneg ? ((tn4_r[SW-1] || (tn4_r == 0)) && (tn4_r >= div4_r))
                : (!tn4_r[SW-1] && (tn4_r <= div4_r));
    swc  = c2d4_r[SW-1];
    swe  = (e1d4_r > e2d4_r);
    adiv = dneg ? -div4_r : div4_r;
    atn  = tn4_r[SW-1] ? -tn4_r : tn4_r;
  end

  logic                  v5_r, rej5_r, qa5_r, qb5_r, dz5_r, col5_r, ins5_r, int5_r;
  logic                  nx5_r, ny5_r;
  segi_pkg::coord_t      c5_r [8];
  segi_pkg::coord_t      a1x5_r, a1y5_r, a2x5_r, a2y5_r, b1x5_r, b1y5_r, b2x5_r, b2y5_r;
  logic signed [SW-1:0]  c1s5_r, c2s5_r, e1s5_r, e2s5_r;
  logic [AW-1:0]         adiv5_r, atn5_r;
  logic [CB-1:0]         aqx5_r, aqy5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c5_r    <= c4_r;
      rej5_r  <= rej4_r;
      qa5_r   <= qa4_r;
      qb5_r   <= qb4_r;
      dz5_r   <= (div4_r == 0);
      col5_r  <= (sn4_r == 0);
      ins5_r  <= ins;
      int5_r  <= intn;
      nx5_r   <= tn4_r[SW-1] ^ qxn4_r ^ dneg;
      ny5_r   <= tn4_r[SW-1] ^ qyn4_r ^ dneg;
      c1s5_r  <= swc ? c2d4_r : '0;
      c2s5_r  <= swc ? '0 : c2d4_r;
      e1s5_r  <= swe ? e2d4_r : e1d4_r;
      e2s5_r  <= swe ? e1d4_r : e2d4_r;
      a1x5_r  <= swc ? c4_r[2] : c4_r[0];
      a1y5_r  <= swc ? c4_r[3] : c4_r[1];
      a2x5_r  <= swc ? c4_r[0] : c4_r[2];
      a2y5_r  <= swc ? c4_r[1] : c4_r[3];
      b1x5_r  <= swe ? c4_r[6] : c4_r[4];
      b1y5_r  <= swe ? c4_r[7] : c4_r[5];
      b2x5_r  <= swe ? c4_r[4] : c4_r[6];
      b2y5_r  <= swe ? c4_r[5] : c4_r[7];
      adiv5_r <= adiv[AW-1:0];
      atn5_r  <= atn[AW-1:0];
      aqx5_r  <= aqx4_r;
      aqy5_r  <= aqy4_r;
    end
  end

  // ---- stage 6: overlap selection, partial products of the offset
  logic             phit;
  segi_pkg::coord_t o1x, o1y, o2x, o2y;

  always_comb begin
    phit = 1'b1;
    o1x  = a1x5_r;
    o1y  = a1y5_r;
    o2x  = a2x5_r;
    o2y  = a2y5_r;
    if (c1s5_r < e1s5_r) begin
      if (c2s5_r < e1s5_r) begin
        phit = 1'b0;
      end else if (c2s5_r < e2s5_r) begin
        o1x = a2x5_r; o1y = a2y5_r; o2x = b1x5_r; o2y = b1y5_r;
      end else begin
        o1x = b1x5_r; o1y = b1y5_r; o2x = b2x5_r; o2y = b2y5_r;
      end
    end else begin
      if (c1s5_r > e2s5_r) begin
        phit = 1'b0;
      end else if (!(c2s5_r < e2s5_r)) begin
        o2x = b2x5_r; o2y = b2y5_r;
      end
    end
  end

  logic                 v6_r, rej6_r, qa6_r, qb6_r, dz6_r, col6_r, ins6_r, int6_r;
  logic                 nx6_r, ny6_r, phit6_r;
  segi_pkg::coord_t     q1x6_r, q1y6_r, q2x6_r, q2y6_r, o1x6_r, o1y6_r, o2x6_r, o2y6_r;
  logic [AW-1:0]        adiv6_r;
  logic [TL+CB-1:0]     plx6_r, ply6_r;
  logic [TH+CB-1:0]     phx6_r, phy6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rej6_r  <= rej5_r;
      qa6_r   <= qa5_r;
      qb6_r   <= qb5_r;
      dz6_r   <= dz5_r;
      col6_r  <= col5_r;
      ins6_r  <= ins5_r;
      int6_r  <= int5_r;
      nx6_r   <= nx5_r;
      ny6_r   <= ny5_r;
      phit6_r <= phit;
      q1x6_r  <= c5_r[4];
      q1y6_r  <= c5_r[5];
      q2x6_r  <= c5_r[6];
      q2y6_r  <= c5_r[7];
      o1x6_r  <= o1x;
      o1y6_r  <= o1y;
      o2x6_r  <= o2x;
      o2y6_r  <= o2y;
      adiv6_r <= adiv5_r;
      plx6_r  <= (TL+CB)'(atn5_r[TL-1:0]) * (TL+CB)'(aqx5_r);
      ply6_r  <= (TL+CB)'(atn5_r[TL-1:0]) * (TL+CB)'(aqy5_r);
      phx6_r  <= (TH+CB)'(atn5_r[AW-1:TL]) * (TH+CB)'(aqx5_r);
      phy6_r  <= (TH+CB)'(atn5_r[AW-1:TL]) * (TH+CB)'(aqy5_r);
    end
  end

  // ---- stage 7: verdict and dividend for half-away rounding
  logic [NW-1:0]   nx, ny;
  logic            peq;
  segi_pkg::side_t side;

  always_comb begin
    nx  = (NW'(phx6_r) << (TL + 1)) + (NW'(plx6_r) << 1) + NW'(adiv6_r);
    ny  = (NW'(phy6_r) << (TL + 1)) + (NW'(ply6_r) << 1) + NW'(adiv6_r);
    peq = (o1x6_r == o2x6_r) && (o1y6_r == o2y6_r);
    side         = '0;
    side.neg_x   = nx6_r;
    side.neg_y   = ny6_r;
    side.cnt     = segi_pkg::HIT_NONE;
    if (!rej6_r) begin
      if (dz6_r) begin
        if (col6_r && phit6_r) begin
          side.fx  = o1x6_r;
          side.fy  = o1y6_r;
          if (peq) begin
            side.cnt = segi_pkg::HIT_ONE;
          end else begin
            side.cnt = segi_pkg::HIT_TWO;
            side.sx  = o2x6_r;
            side.sy  = o2y6_r;
          end
        end
      end else if (qa6_r) begin
        side.cnt = segi_pkg::HIT_ONE;
        side.fx  = q1x6_r;
        side.fy  = q1y6_r;
      end else if (qb6_r) begin
        side.cnt = segi_pkg::HIT_ONE;
        side.fx  = q2x6_r;
        side.fy  = q2y6_r;
      end else if (ins6_r && int6_r) begin
        side.cnt     = segi_pkg::HIT_ONE;
        side.use_div = 1'b1;
        side.fx      = q1x6_r;
        side.fy      = q1y6_r;
      end
    end
  end

  logic            v7_r;
  segi_pkg::cell_t cell7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell7_r.rem_x <= nx[NW-1:QB];
      cell7_r.rem_y <= ny[NW-1:QB];
      cell7_r.nq_x  <= nx[QB-1:0];
      cell7_r.nq_y  <= ny[QB-1:0];
      cell7_r.den   <= {adiv6_r, 1'b0};
      cell7_r.side  <= side;
    end
  end

  assign out_valid = v7_r;
  assign out_cell  = cell7_r;

endmodule

// ===== hw/rtl/segment_intersection.sv =====
// Top level of the segment intersection block: front stages, divider cell row, output skid.
//
// Takes one pair of integer segments p1..p2 and q1..q2 per request and returns one result
// request: hit_count (0 none, 1 single point, 2 overlapping stretch) with the first point
// and, for a stretch, its other end; unused points are zero. All arithmetic is exact
// integer. A new pair is taken every cycle while the skid entry is free. From input request
// to output valid a pair passes seven geometry stages, a row of 33 division cells (one
// quotient bit per cell, set by the 33-bit rounded offset), and the output register. The
// cell row holds up to 33 pairs in flight. A two-entry output stage (register plus skid)
// lets input requests keep flowing while a result waits; input stalls only once the skid is full.
module segment_intersection (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // p1_x, p1_y, p2_x, p2_y, q1_x, q1_y, q2_x, q2_y (32 bits each), lowest first
  input  logic [segi_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // hit_count (2), first_x, first_y, second_x, second_y (32 each), zero padded
  output logic [segi_pkg::OUT_W-1:0] out_tdata
);

  localparam int QB = segi_pkg::QB;
  localparam int CB = segi_pkg::CB;
  localparam int IW = segi_pkg::IW;

  logic en;
  logic out_valid_r, skid_valid_r;
  logic [segi_pkg::OUT_W-1:0] out_data_r, skid_data_r;

  // Advance the whole pipe whenever the skid entry is free.
  assign en        = !skid_valid_r;
  assign in_tready = en;

  logic            chain_v [QB+1];
  segi_pkg::cell_t chain_c [QB+1];

  segi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .out_valid (chain_v[0]),
    .out_cell  (chain_c[0])
  );

  // One quotient bit per cell, MSB first.
  for (genvar g = 0; g < QB; g++) begin : g_cell
    segi_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (chain_v[g]),
      .in_cell   (chain_c[g]),
      .out_valid (chain_v[g+1]),
      .out_cell  (chain_c[g+1])
    );
  end

  // Apply sign to the rounded offset and add it to q1.
  segi_pkg::cell_t          last;
  logic [QB-1:0]            offx, offy;
  segi_pkg::coord_t         fx, fy;
  logic [IW-1:0]            fxe, fye, sxe, sye;
  logic [segi_pkg::OUT_W-1:0] res;
  logic                     push, out_free;

  always_comb begin
    last = chain_c[QB];
    offx = last.side.neg_x ? -last.nq_x : last.nq_x;
    offy = last.side.neg_y ? -last.nq_y : last.nq_y;
    fx   = last.side.use_div ? (last.side.fx + offx[CB-1:0]) : last.side.fx;
    fy   = last.side.use_div ? (last.side.fy + offy[CB-1:0]) : last.side.fy;
    fxe  = IW'(fx);
    fye  = IW'(fy);
    sxe  = IW'(last.side.sx);
    sye  = IW'(last.side.sy);
    res  = segi_pkg::OUT_W'({sye, sxe, fye, fxe, last.side.cnt});
  end

  assign push     = en && chain_v[QB];
  assign out_free = !out_valid_r || out_tready;

  // Output register with skid: hold a result while the sink stalls, park the next one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (out_free) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end else if (out_free && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/segi_checker.sv =====
// Port-level checks of the segment intersection block, bound to the top level.
module segi_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [segi_pkg::OUT_W-1:0] out_tdata
);

  localparam int IW = segi_pkg::IW;

  logic [1:0]    hit;
  logic [IW-1:0] f_x, f_y, s_x, s_y;

  assign hit = out_tdata[1:0];
  assign f_x = out_tdata[2 +: IW];
  assign f_y = out_tdata[2 + IW +: IW];
  assign s_x = out_tdata[2 + 2*IW +: IW];
  assign s_y = out_tdata[2 + 3*IW +: IW];

  a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (hit == segi_pkg::HIT_NONE || hit == segi_pkg::HIT_ONE ||
                    hit == segi_pkg::HIT_TWO))
    else $error("hit count out of range");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && hit == segi_pkg::HIT_NONE) |->
      (f_x == '0 && f_y == '0 && s_x == '0 && s_y == '0))
    else $error("points not cleared on a miss");

  a_one_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && hit == segi_pkg::HIT_ONE) |-> (s_x == '0 && s_y == '0))
    else $error("second point set on a single hit");

  a_two_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && hit == segi_pkg::HIT_TWO) |-> (f_x != s_x || f_y != s_y))
    else $error("overlap ends coincide");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result request changed");

endmodule

bind segment_intersection segi_checker u_segi_checker (.*);
